// ===== src/wsd_pkg.sv =====
`default_nettype none
package wsd_pkg;

  localparam int ByteW   = 8;
  localparam int StatusW = 3;
  localparam int LenW    = 64;
  localparam int KeyW    = 32;

  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [StatusW-1:0] status_t;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_SHORT_HDR = 3'd1;
  localparam status_t ST_SHORT_EXT = 3'd2;
  localparam status_t ST_SHORT_KEY = 3'd3;
  localparam status_t ST_SHORT_PAY = 3'd4;

endpackage
`default_nettype wire

// ===== src/wsd_in_if.sv =====
`default_nettype none
interface wsd_in_if;
  import wsd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface
`default_nettype wire

// ===== src/wsd_out_if.sv =====
`default_nettype none
interface wsd_out_if;
  import wsd_pkg::*;

  logic    valid;
  logic    ready;
  byte_t   payload_byte;
  logic    data_valid;
  logic    last_payload;
  status_t status;

  modport source (output valid, output payload_byte, output data_valid,
                  output last_payload, output status, input ready);
  modport sink   (input valid, input payload_byte, input data_valid,
                  input last_payload, input status, output ready);
endinterface
`default_nettype wire

// ===== src/websocket_frame_deframer.sv =====
// WebSocket frame deframer, receive side.
// in_ch carries one buffer byte per item, end_of_buffer marking the buffer's
// last byte. out_ch carries at most one result per input item: a payload byte
// (data_valid 1), or an empty-frame / error marker (data_valid 0,
// last_payload 1, status naming the missing part).
// Header, extended length and key bytes give at most a marker; trailing bytes none.
// Pipeline: input register, then one pass of parse/unmask logic into the
// result register. A byte's result is registered when the byte leaves the
// input register, which waits while the result register is full and stalled.
// Throughput is one byte per cycle while out_ch is not stalled; the 64-bit
// remaining-length counter updates in the same single pass.
// The input register takes a new byte while a result waits in the output
// register; once both are full and out_ch.ready is low, in_ch.ready drops and
// nothing is lost. Bytes without a result advance whenever the output
// register is free or being emptied.
// Synchronous active-low reset empties both registers and returns the parser
// to the first header byte of a new buffer.
`default_nettype none
module websocket_frame_deframer (
  input  wire        clk,
  input  wire        rst_n,
  wsd_in_if.sink     in_ch,
  wsd_out_if.source  out_ch
);
  import wsd_pkg::*;

  localparam logic [2:0] PH_HDR0  = 3'd0;
  localparam logic [2:0] PH_HDR1  = 3'd1;
  localparam logic [2:0] PH_EXT   = 3'd2;
  localparam logic [2:0] PH_KEY   = 3'd3;
  localparam logic [2:0] PH_BODY  = 3'd4;
  localparam logic [2:0] PH_DRAIN = 3'd5;

  localparam logic [6:0] LEN16 = 7'd126;
  localparam logic [6:0] LEN64 = 7'd127;

  // input register
  logic  in_valid_r;
  byte_t in_data_r;
  logic  in_eob_r;

  // parser state; ext_r holds extended length bytes still expected minus one
  logic [2:0]      phase_r, phase_nxt;
  logic [2:0]      ext_r, ext_nxt;
  logic [LenW-1:0] rem_r, rem_nxt;
  logic [KeyW-1:0] key_r, key_nxt;
  logic            masked_r, masked_nxt;
  logic [1:0]      kidx_r, kidx_nxt;

  // result register
  logic    out_valid_r;
  byte_t   out_byte_r, out_byte_nxt;
  logic    out_dv_r, out_dv_nxt;
  logic    out_last_r, out_last_nxt;
  status_t out_st_r, out_st_nxt;
  logic    emit;

  logic  advance;
  logic  do_after, do_body;
  byte_t kb;

  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_comb begin
    phase_nxt    = phase_r;
    ext_nxt      = ext_r;
    rem_nxt      = rem_r;
    key_nxt      = key_r;
    masked_nxt   = masked_r;
    kidx_nxt     = kidx_r;
    emit         = 1'b0;
    out_byte_nxt = '0;
    out_dv_nxt   = 1'b0;
    out_last_nxt = 1'b1;
    out_st_nxt   = ST_OK;
    do_after     = 1'b0;
    do_body      = 1'b0;
    kb           = key_r[(KeyW-ByteW) - ByteW*kidx_r +: ByteW];

    case (phase_r)
      PH_HDR1: begin
        masked_nxt = in_data_r[7];
        rem_nxt    = '0;
        if (in_data_r[6:0] == LEN16 || in_data_r[6:0] == LEN64) begin
          ext_nxt = (in_data_r[6:0] == LEN16) ? 3'd1 : 3'd7;
          if (in_eob_r) begin
            phase_nxt  = PH_HDR0;
            emit       = 1'b1;
            out_st_nxt = ST_SHORT_EXT;
          end else begin
            phase_nxt = PH_EXT;
          end
        end else begin
          rem_nxt  = {{(LenW-7){1'b0}}, in_data_r[6:0]};
          do_after = 1'b1;
        end
      end
      PH_EXT: begin
        rem_nxt = {rem_r[LenW-ByteW-1:0], in_data_r};
        ext_nxt = ext_r - 3'd1;
        if (ext_r == 3'd0) begin
          do_after = 1'b1;
        end else if (in_eob_r) begin
          phase_nxt  = PH_HDR0;
          emit       = 1'b1;
          out_st_nxt = ST_SHORT_EXT;
        end
      end
      PH_KEY: begin
        key_nxt = {key_r[KeyW-ByteW-1:0], in_data_r};
        if (kidx_r == 2'd3) begin
          do_body = 1'b1;
        end else begin
          kidx_nxt = kidx_r + 2'd1;
          if (in_eob_r) begin
            phase_nxt  = PH_HDR0;
            emit       = 1'b1;
            out_st_nxt = ST_SHORT_KEY;
          end
        end
      end
      PH_BODY: begin
        kidx_nxt = kidx_r + 2'd1;
        rem_nxt  = rem_r - 1'b1;
        if (rem_nxt == '0) begin
          phase_nxt    = in_eob_r ? PH_HDR0 : PH_DRAIN;
          emit         = 1'b1;
          out_byte_nxt = masked_r ? (in_data_r ^ kb) : in_data_r;
          out_dv_nxt   = 1'b1;
        end else if (in_eob_r) begin
          phase_nxt  = PH_HDR0;
          emit       = 1'b1;
          out_st_nxt = ST_SHORT_PAY;
        end else begin
          emit         = 1'b1;
          out_byte_nxt = masked_r ? (in_data_r ^ kb) : in_data_r;
          out_dv_nxt   = 1'b1;
          out_last_nxt = 1'b0;
        end
      end
      PH_DRAIN: begin
        if (in_eob_r) begin
          phase_nxt = PH_HDR0;
        end
      end
      default: begin
        if (in_eob_r) begin
          phase_nxt  = PH_HDR0;
          emit       = 1'b1;
          out_st_nxt = ST_SHORT_HDR;
        end else begin
          phase_nxt = PH_HDR1;
        end
      end
    endcase

    if (do_after) begin
      if (masked_nxt) begin
        kidx_nxt = 2'd0;
        key_nxt  = '0;
        if (in_eob_r) begin
          phase_nxt  = PH_HDR0;
          emit       = 1'b1;
          out_st_nxt = ST_SHORT_KEY;
        end else begin
          phase_nxt = PH_KEY;
        end
      end else begin
        do_body = 1'b1;
      end
    end

    if (do_body) begin
      kidx_nxt = 2'd0;
      if (rem_nxt == '0) begin
        phase_nxt = in_eob_r ? PH_HDR0 : PH_DRAIN;
        emit      = 1'b1;
      end else if (in_eob_r) begin
        phase_nxt  = PH_HDR0;
        emit       = 1'b1;
        out_st_nxt = ST_SHORT_PAY;
      end else begin
        phase_nxt = PH_BODY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_HDR0;
      ext_r       <= '0;
      rem_r       <= '0;
      key_r       <= '0;
      masked_r    <= 1'b0;
      kidx_r      <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= emit;
        phase_r     <= phase_nxt;
        ext_r       <= ext_nxt;
        rem_r       <= rem_nxt;
        key_r       <= key_nxt;
        masked_r    <= masked_nxt;
        kidx_r      <= kidx_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_data_r <= in_ch.data_byte;
      in_eob_r  <= in_ch.end_of_buffer;
    end
    if (advance && emit) begin
      out_byte_r <= out_byte_nxt;
      out_dv_r   <= out_dv_nxt;
      out_last_r <= out_last_nxt;
      out_st_r   <= out_st_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.payload_byte = out_byte_r;
  assign out_ch.data_valid   = out_dv_r;
  assign out_ch.last_payload = out_last_r;
  assign out_ch.status       = out_st_r;

  a_dv_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_dv_r) |-> (out_st_r == ST_OK))
    else $error("payload item carries an error status");

  a_err_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r != ST_OK) |-> (out_last_r && !out_dv_r && out_byte_r == '0))
    else $error("error item is not a closing marker");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with empty result register");

  a_body_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (rem_r != '0))
    else $error("payload phase with no bytes left");

endmodule
`default_nettype wire
